>>> design/lru_validated_object_cache_core_macros.svh
// Assertion macros for the object cache checker
`ifndef LRU_VALIDATED_OBJECT_CACHE_CORE_MACROS_SVH
`define LRU_VALIDATED_OBJECT_CACHE_CORE_MACROS_SVH
`define LVOC_ASSERT_IMP(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("violation");
`define LVOC_ASSERT_NXT(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("violation");
`endif

>>> design/lvoc_pkg.sv
// Shared types and constants of the object cache
`default_nettype none
package lvoc_pkg;
  localparam int KeyBits    = 32;
  localparam int HandleBits = 16;

  localparam logic [1:0] ModeLookup  = 2'd0;
  localparam logic [1:0] ModeStore   = 2'd1;
  localparam logic [1:0] ModeDispose = 2'd2;
  localparam logic [1:0] ModeUnused  = 2'd3;
  localparam logic [7:0] LimitReset  = 8'd100;

  typedef struct packed {
    logic [1:0]            mode;
    logic [KeyBits-1:0]    key;
    logic                  file_present;
    logic [39:0]           file_size;
    logic [31:0]           mod_time;
    logic [31:0]           now;
    logic [HandleBits-1:0] handle;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic [HandleBits-1:0] handle_out;
    logic                  released;
    logic [HandleBits-1:0] released_handle;
  } rsp_t;

  typedef enum logic [2:0] {
    StIdle, StScan, StDecide, StEvict, StFree, StWrite, StDone
  } state_e;
endpackage
`default_nettype wire

>>> design/lvoc_ram.sv
// Generic single-port RAM with registered read
`default_nettype none
module lvoc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

>>> design/lru_validated_object_cache_core.sv
// The result strobe follows a scan of every slot, by sequential reads of the single entry
// memory, one slot per cycle, then a decision step and an optional write-back; an insert
// first evicts and scans the valid bits a second time for a free slot.
// One transaction at a time; busy_o is high from acceptance to the result strobe,
// and the next transaction is accepted in the cycle after the strobe at the earliest.
// The result strobe is high for one cycle; the receiver cannot stall.
// Reset clears valid bits, count and limit (100); entry memory is not cleared.
`default_nettype none
module lru_validated_object_cache_core
  import lvoc_pkg::*;
#(
  parameter int CAPACITY    = 128
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire req_t       req_i,
  output logic            done_o,
  output rsp_t            rsp_o,
  input  wire logic       psel,
  input  wire logic       penable,
  input  wire logic       pwrite,
  input  wire logic [0:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = KeyBits + HandleBits + 40 + 32 + 32;

  logic [7:0] limit_q;
  assign pready = 1'b1;
  assign prdata = {24'd0, limit_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= LimitReset;
    else if (psel && penable && pwrite && paddr == 1'b0) limit_q <= pwdata[7:0];
  end
  logic [CW-1:0] lim;
  always_comb begin
    if (limit_q == 8'd0) lim = CW'(1);
    else if (32'(limit_q) > CAPACITY) lim = CW'(CAPACITY);
    else lim = CW'(limit_q);
  end

  state_e st_q, st_d;
  req_t r_q;
  logic [CAPACITY-1:0] valid_q;
  logic [CW-1:0] cnt_q;
  logic [AW:0] idx_q;
  logic [AW-1:0] addr;
  logic rvld_q;
  logic [AW-1:0] ridx_q;
  logic we;
  logic [EW-1:0] wdata, rdata;
  logic fnd_q; logic [AW-1:0] fidx_q; logic [EW-1:0] fent_q;
  logic old_q; logic [AW-1:0] oidx_q; logic [31:0] olu_q; logic [HandleBits-1:0] oh_q;
  logic frf_q; logic [AW-1:0] free_q;
  rsp_t rsp_q, dec_rsp;
  logic [AW-1:0] waddr_q;

  logic [KeyBits-1:0] e_key;
  logic [HandleBits-1:0] e_h;
  logic [31:0] e_lu;
  assign {e_key, e_h} = rdata[EW-1 -: KeyBits + HandleBits];
  assign e_lu = rdata[31:0];

  lvoc_ram #(.Width(EW), .Depth(CAPACITY)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  logic [HandleBits-1:0] rh;
  assign rh = r_q.handle[HandleBits-1:0];
  logic keym, hm;
  assign keym = e_key == r_q.key[KeyBits-1:0];
  assign hm = e_h == rh;

  logic [HandleBits-1:0] fent_h;
  logic fresh;
  assign fent_h = fent_q[EW-KeyBits-1 -: HandleBits];
  assign fresh = r_q.file_present && fent_q[64 +: 40] == r_q.file_size &&
                 fent_q[32 +: 32] == r_q.mod_time;

  always_comb begin
    st_d = st_q; we = 1'b0; addr = idx_q[AW-1:0]; wdata = fent_q; dec_rsp = '0;
    case (st_q)
      StIdle: if (start_i) st_d = StScan;
      StScan: if (idx_q == (AW+1)'(CAPACITY) && !rvld_q) st_d = StDecide;
      StDecide: begin
        st_d = StDone;
        case (r_q.mode)
          ModeLookup: if (fnd_q) begin
            if (fresh) begin
              dec_rsp.hit = 1'b1; dec_rsp.handle_out = fent_h; st_d = StWrite;
            end else begin
              dec_rsp.released = 1'b1; dec_rsp.released_handle = fent_h;
            end
          end
          ModeStore: if (r_q.file_present) begin
            if (fnd_q) begin
              dec_rsp.released = 1'b1; dec_rsp.released_handle = fent_h; st_d = StWrite;
            end else st_d = StEvict;
          end
          default: ;
        endcase
      end
      StEvict: st_d = StFree;
      StFree: if (idx_q == (AW+1)'(CAPACITY)) st_d = frf_q ? StWrite : StDone;
      StWrite: begin
        st_d = StDone; we = 1'b1; addr = waddr_q;
        wdata = {r_q.key[KeyBits-1:0], rh, r_q.file_size, r_q.mod_time, r_q.now};
        if (r_q.mode == ModeLookup) wdata = {fent_q[EW-1:32], r_q.now};
        else if (fnd_q) wdata = {fent_q[EW-1 -: KeyBits], rh, r_q.file_size,
                                 r_q.mod_time, fent_q[31:0]};
      end
      StDone: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; valid_q <= '0; cnt_q <= '0; idx_q <= '0; rvld_q <= 1'b0;
      fnd_q <= 1'b0; old_q <= 1'b0; frf_q <= 1'b0;
    end else begin
      st_q <= st_d;
      rvld_q <= 1'b0;
      case (st_q)
        StIdle: if (start_i) begin
          idx_q <= '0; fnd_q <= 1'b0; old_q <= 1'b0; frf_q <= 1'b0;
        end
        StScan: begin
          if (idx_q != (AW+1)'(CAPACITY)) begin
            idx_q <= idx_q + 1'b1; rvld_q <= 1'b1; ridx_q <= idx_q[AW-1:0];
          end
          if (rvld_q && valid_q[ridx_q]) begin
            if (!fnd_q && ((r_q.mode == ModeDispose) ? hm : keym)) begin
              fnd_q <= 1'b1; fidx_q <= ridx_q; fent_q <= rdata;
            end
            if (!old_q || e_lu < olu_q) begin
              old_q <= 1'b1; oidx_q <= ridx_q; olu_q <= e_lu; oh_q <= e_h;
            end
          end
        end
        StDecide: begin
          rsp_q <= dec_rsp;
          waddr_q <= fidx_q;
          if (fnd_q && ((r_q.mode == ModeLookup && !fresh) || r_q.mode == ModeDispose)) begin
            valid_q[fidx_q] <= 1'b0; cnt_q <= cnt_q - 1'b1;
          end
        end
        StEvict: begin
          if (cnt_q >= lim && old_q) begin
            rsp_q.released <= 1'b1; rsp_q.released_handle <= oh_q;
            valid_q[oidx_q] <= 1'b0; cnt_q <= cnt_q - 1'b1;
          end
          idx_q <= '0;
        end
        StFree: begin
          if (idx_q != (AW+1)'(CAPACITY)) begin
            idx_q <= idx_q + 1'b1;
            if (!frf_q && !valid_q[idx_q[AW-1:0]]) begin
              frf_q <= 1'b1; waddr_q <= idx_q[AW-1:0];
            end
          end
        end
        StWrite: if (r_q.mode == ModeStore && !fnd_q) begin
          valid_q[waddr_q] <= 1'b1; cnt_q <= cnt_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && start_i) r_q <= req_i;
  end

  assign busy_o = st_q != StIdle;
  assign done_o = st_q == StDone;
  assign rsp_o = rsp_q;
endmodule
`default_nettype wire

>>> design/lvoc_checker.sv
// Port-level checker for the object cache, bound to the top level
`default_nettype none
`include "lru_validated_object_cache_core_macros.svh"
module lvoc_checker
  import lvoc_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic done_o,
  input wire rsp_t rsp_o
);
  `LVOC_ASSERT_IMP(a_done_busy, clk_i, rst_ni, done_o, busy_o)
  `LVOC_ASSERT_NXT(a_start_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `LVOC_ASSERT_NXT(a_done_free, clk_i, rst_ni, done_o, !busy_o)
  `LVOC_ASSERT_IMP(a_hit_norel, clk_i, rst_ni, done_o && rsp_o.hit, !rsp_o.released)
endmodule
bind lru_validated_object_cache_core lvoc_checker u_chk (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .rsp_o
);
`default_nettype wire
